// ===== design/assert_macros.svh =====
// Assertion macros used by the design file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pgmq_pkg.sv =====
// Shared types, stream layout and codes of the priority-gated multi-queue.
`default_nettype none

package pgmq_pkg;

    // Stream widths and field placement.
    localparam int ITEM_W      = 64;
    localparam int QID_W       = 3;
    localparam int LEN_W       = 8;
    localparam int SIZE_W      = 16;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;
    localparam int S_TDATA_W   = 96;
    localparam int S_TUSER_W   = CMD_W;
    localparam int M_TDATA_W   = 72;
    localparam int M_TUSER_W   = STAT_W;
    localparam int QID_LSB     = 0;
    localparam int ITEM_LSB    = QID_LSB + QID_W;
    localparam int LEN_LSB     = ITEM_LSB + ITEM_W;
    localparam int SIZE_LSB    = LEN_LSB + LEN_W;
    localparam int M_PAD_W     = M_TDATA_W - ITEM_W - 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/pgmq_ctrl.sv =====
// Sequencing state machine: accept, execute, load the result register.
`default_nettype none

module pgmq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire pgmq_pkg::t_dp_stat i_stat,
    output pgmq_pkg::t_dp_cmd       o_cmd
);
    import pgmq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands to the datapath; no transfer is taken while reset is held.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_s_tready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_rst_n && i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/pgmq_dp.sv =====
// Datapath: input capture, queue indices, occupancy, slot memory and result register.
`default_nettype none

module pgmq_dp #(
    parameter int NUM_QUEUES    = 8,
    parameter int QUEUE_SLOTS   = 16,
    parameter int ELEMENT_BYTES = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pgmq_pkg::t_dp_cmd                 i_cmd,
    output pgmq_pkg::t_dp_stat                     o_stat,
    input  wire logic [pgmq_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  wire logic [pgmq_pkg::S_TUSER_W-1:0]    i_s_tuser,
    input  wire logic                              i_m_tready,
    output logic                                   o_m_tvalid,
    output logic      [pgmq_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic      [pgmq_pkg::M_TUSER_W-1:0]    o_m_tuser
);
    import pgmq_pkg::*;

    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IW    = $clog2(QUEUE_SLOTS);
    localparam int DEPTH = NUM_QUEUES * QUEUE_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = 8 * ELEMENT_BYTES;

    // Captured request.
    logic [CMD_W-1:0]  r_cmd;
    logic [QID_W-1:0]  r_qid;
    logic [EW-1:0]     r_item;
    logic [LEN_W-1:0]  r_len;
    logic [SIZE_W-1:0] r_size;

    // Queue state.
    logic [IW-1:0]         r_rd_idx [NUM_QUEUES];
    logic [IW-1:0]         r_wr_idx [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_busy;
    logic [EW-1:0]         r_mem [DEPTH];
    logic [EW-1:0]         r_rdata;

    // Outcome of the executed request.
    logic [STAT_W-1:0] r_status;
    logic              r_pop_ok;

    // Result register.
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [ITEM_W-1:0] r_out_item;
    logic              r_out_any;
    logic              r_out_higher;

    logic [31:0]           w_qid_wide;
    logic [QW-1:0]         w_q;
    logic                  w_valid_q;
    logic [IW-1:0]         w_cur_rd;
    logic [IW-1:0]         w_cur_wr;
    logic [IW-1:0]         w_rd_next;
    logic [IW-1:0]         w_wr_next;
    logic [NUM_QUEUES-1:0] w_higher_mask;
    logic                  w_higher_busy;
    logic                  w_full;
    logic                  w_q_busy;
    logic                  w_len_match;
    logic                  w_size_match;
    logic [STAT_W-1:0]     n_status;
    logic                  w_push_ok;
    logic                  w_pop_ok;
    logic [AW-1:0]         w_addr;

    // Request capture on an input transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= i_s_tuser;
            r_qid  <= i_s_tdata[QID_LSB +: QID_W];
            r_item <= i_s_tdata[ITEM_LSB +: EW];
            r_len  <= i_s_tdata[LEN_LSB +: LEN_W];
            r_size <= i_s_tdata[SIZE_LSB +: SIZE_W];
        end
    end

    // Queue selection and index arithmetic.
    assign w_qid_wide = 32'(r_qid);
    assign w_q        = w_qid_wide[QW-1:0];
    assign w_valid_q  = (w_qid_wide < 32'(NUM_QUEUES));
    assign w_cur_rd   = r_rd_idx[w_q];
    assign w_cur_wr   = r_wr_idx[w_q];
    assign w_rd_next  = (32'(w_cur_rd) == 32'(QUEUE_SLOTS - 1)) ? '0 : w_cur_rd + IW'(1);
    assign w_wr_next  = (32'(w_cur_wr) == 32'(QUEUE_SLOTS - 1)) ? '0 : w_cur_wr + IW'(1);
    assign w_full     = (w_wr_next == w_cur_rd);
    assign w_q_busy   = r_busy[w_q];

    // Queues above the selected one.
    always_comb begin
        for (int i = 0; i < NUM_QUEUES; i++) begin
            w_higher_mask[i] = (32'(i) > w_qid_wide);
        end
    end
    assign w_higher_busy = |(r_busy & w_higher_mask);

    // Settings check against the built sizes.
    assign w_len_match  = (32'(r_len) == 32'(QUEUE_SLOTS));
    assign w_size_match = (32'(r_size) == 32'(ELEMENT_BYTES));

    // Command decode.
    always_comb begin
        n_status  = STAT_BAD;
        w_push_ok = 1'b0;
        w_pop_ok  = 1'b0;
        if (w_valid_q) begin
            unique case (r_cmd)
                CMD_PUSH: begin
                    if (w_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_status  = STAT_OK;
                        w_push_ok = 1'b1;
                    end
                end
                CMD_POP: begin
                    if (w_higher_busy || !w_q_busy) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_status = STAT_OK;
                        w_pop_ok = 1'b1;
                    end
                end
                CMD_CHECK: begin
                    n_status = (w_len_match && w_size_match) ? STAT_OK : STAT_BAD;
                end
                default: begin
                    n_status = STAT_BAD;
                end
            endcase
        end
    end

    // Slot address: a push writes at the write index, anything else reads at the read index.
    assign w_addr = AW'(32'(w_q) * QUEUE_SLOTS
                        + 32'((r_cmd == CMD_PUSH) ? w_cur_wr : w_cur_rd));

    // Slot memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_push_ok) begin
                r_mem[w_addr] <= r_item;
            end
            r_rdata <= r_mem[w_addr];
        end
    end

    // Index and occupancy update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_rd_idx[i] <= '0;
                r_wr_idx[i] <= '0;
            end
            r_busy <= '0;
        end else if (i_cmd.exec) begin
            if (w_push_ok) begin
                r_wr_idx[w_q] <= w_wr_next;
                r_busy[w_q]   <= 1'b1;
            end
            if (w_pop_ok) begin
                r_rd_idx[w_q] <= w_rd_next;
                r_busy[w_q]   <= (w_rd_next != w_cur_wr);
            end
        end
    end

    // Outcome kept until the result register is loaded.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= w_pop_ok;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload; pending flags come from the updated occupancy.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_item   <= r_pop_ok ? ITEM_W'(r_rdata) : '0;
            r_out_any    <= |r_busy;
            r_out_higher <= w_valid_q && w_higher_busy;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tuser       = r_out_status;
    assign o_m_tdata       = {M_PAD_W'(0), r_out_higher, r_out_any, r_out_item};

endmodule

`default_nettype wire

// ===== design/priority_gated_multi_queue_top.sv =====
// Top level of the priority-gated multi-queue: controller, datapath and checks.
//
//  Channel | Direction | tdata (lowest bit up)                          | tuser
//  s_      | in        | queue_id, item_in, check_length, check_size    | command
//  m_      | out       | item_out, any_pending, higher_pending          | status
//
// Each item passes through the transfer in, the index update together with the registered
// slot memory access, and the load of the result register. For a pop, the memory's
// registered read port delivers the element ahead of that load.
// Reset is synchronous and clears the indices and the occupancy flags; the slot memory
// is not cleared and needs no clearing pass, so items are taken right after reset.
// A new item is taken while the previous result still waits; the block then holds in its
// last step until the result register is free.
`default_nettype none
`include "assert_macros.svh"

module priority_gated_multi_queue_top #(
    parameter int NUM_QUEUES    = 8,
    parameter int QUEUE_SLOTS   = 16,
    parameter int ELEMENT_BYTES = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // queue_id [2:0], item_in [66:3], check_length [74:67], check_size [90:75], zeros
    input  wire logic [pgmq_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // command [1:0]
    input  wire logic [pgmq_pkg::S_TUSER_W-1:0]    i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // item_out [63:0], any_pending [64], higher_pending [65], zeros
    output logic      [pgmq_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // status [1:0]
    output logic      [pgmq_pkg::M_TUSER_W-1:0]    o_m_tuser
);
    import pgmq_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer.
    pgmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Queue datapath.
    pgmq_dp #(
        .NUM_QUEUES    (NUM_QUEUES),
        .QUEUE_SLOTS   (QUEUE_SLOTS),
        .ELEMENT_BYTES (ELEMENT_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Checks on the sequencing and the result contents.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input taken again in the cycle after a transfer")
    `ASSERT_IMPLY(a_load_when_free, i_clk, i_rst_n, w_cmd.load_out, !o_m_tvalid || i_m_tready, "result register overwritten while a result waits")
    `ASSERT_IMPLY(a_item_zero_unless_ok, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != STAT_OK), o_m_tdata[ITEM_W-1:0] == '0, "element returned with a failing status")
    `ASSERT_IMPLY(a_higher_implies_any, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[ITEM_W+1], o_m_tdata[ITEM_W], "higher queue pending while no queue is pending")

endmodule

`default_nettype wire

// ===== bench/priority_gated_multi_queue_top_tb.sv =====
// Self-checking bench for the priority-gated multi-queue over its stream ports.
`timescale 1ns / 100ps

module priority_gated_multi_queue_top_tb;
    import pgmq_pkg::*;

    localparam int N_QUEUES     = 8;
    localparam int N_SLOTS      = 16;
    localparam int ELEM_BYTES   = 8;
    localparam int MAX_FILL     = N_SLOTS - 1;
    localparam int LIMIT_CYCLES = 200000;
    localparam logic [ITEM_W-1:0] ELEM_MASK =
        (ELEM_BYTES >= 8) ? {ITEM_W{1'b1}} : ((64'd1 << (8 * ELEM_BYTES)) - 64'd1);

    // Command code that the block does not know.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    // One request as it travels on the slave side.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] size;
        logic [LEN_W-1:0]  len;
        logic [ITEM_W-1:0] data;
        logic [QID_W-1:0]  qid;
    } t_req;

    // One reply as it travels on the master side.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ITEM_W-1:0] data;
        logic              any_busy;
        logic              higher_busy;
    } t_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic [S_TUSER_W-1:0] i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;

    // Queue state as the bench predicts it.
    logic [3:0]        rd_idx [N_QUEUES];
    logic [3:0]        wr_idx [N_QUEUES];
    logic [ITEM_W-1:0] slot_mem [N_QUEUES][N_SLOTS];

    // Fill levels as the stimulus generator tracks them, ahead of the block.
    int fill_level [N_QUEUES];

    t_req   op_backlog[$];
    t_reply awaited_replies[$];

    int ops_queued = 0;
    int ops_taken = 0;
    int replies_due = 0;
    int err_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int cycle_cnt = 0;
    logic s_taken = 1'b0;

    int n_push_ok = 0, n_full = 0, n_pop_ok = 0, n_pop_empty = 0;
    int n_check_ok = 0, n_bad = 0;

    priority_gated_multi_queue_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Free-running clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run limit: ends the run with a failure once the cycle limit is reached.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("%0t: run stopped at the cycle limit, %0d replies outstanding",
                     $time, replies_due);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // True when any queue numbered from first upwards holds an element.
    function automatic logic busy_from(input int first);
        logic hit;
        hit = 1'b0;
        for (int q = first; q < N_QUEUES; q++)
            if (rd_idx[q] != wr_idx[q])
                hit = 1'b1;
        return hit;
    endfunction

    // Applies one request to the predicted queue state and returns its reply.
    function automatic t_reply apply_queue_op(input t_req r);
        t_reply y;
        logic [3:0] nxt;
        int q;
        q = int'(r.qid);
        y.status = STAT_BAD;
        y.data = '0;
        if (q < N_QUEUES) begin
            case (r.cmd)
                CMD_PUSH: begin
                    nxt = wr_idx[q] + 4'd1;
                    if (nxt == rd_idx[q]) begin
                        y.status = STAT_FULL;
                    end else begin
                        slot_mem[q][wr_idx[q]] = r.data & ELEM_MASK;
                        wr_idx[q] = nxt;
                        y.status = STAT_OK;
                    end
                end
                CMD_POP: begin
                    if (busy_from(q + 1) || rd_idx[q] == wr_idx[q]) begin
                        y.status = STAT_EMPTY;
                    end else begin
                        y.data = slot_mem[q][rd_idx[q]];
                        rd_idx[q] = rd_idx[q] + 4'd1;
                        y.status = STAT_OK;
                    end
                end
                CMD_CHECK: begin
                    if (int'(r.len) == N_SLOTS && int'(r.size) == ELEM_BYTES)
                        y.status = STAT_OK;
                    else
                        y.status = STAT_BAD;
                end
                default: y.status = STAT_BAD;
            endcase
        end
        y.any_busy = busy_from(0);
        y.higher_busy = (q < N_QUEUES) && busy_from(q + 1);

        // Tally what the run has exercised.
        if (r.cmd == CMD_PUSH && y.status == STAT_OK) n_push_ok++;
        else if (y.status == STAT_FULL) n_full++;
        else if (r.cmd == CMD_POP && y.status == STAT_OK) n_pop_ok++;
        else if (y.status == STAT_EMPTY) n_pop_empty++;
        else if (r.cmd == CMD_CHECK && y.status == STAT_OK) n_check_ok++;
        else n_bad++;
        return y;
    endfunction

    task automatic flag_mismatch(input string field, input logic [ITEM_W-1:0] want,
                                 input logic [ITEM_W-1:0] got);
        err_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    // Driver: presents backlog items on the slave side and paces the master side.
    always @(negedge i_clk) begin : drive
        t_req nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            if (!i_s_tvalid || s_taken) begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = op_backlog.pop_front();
                    i_s_tdata  <= {5'b0, nxt.size, nxt.len, nxt.data, nxt.qid};
                    i_s_tuser  <= nxt.cmd;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Monitor: checks each reply transfer and predicts each request transfer.
    always @(posedge i_clk) begin : observe
        t_reply got, want;
        t_req   taken;
        int     acc, ret;
        acc = 0;
        ret = 0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                ret = 1;
                got.status      = o_m_tuser;
                got.data        = o_m_tdata[ITEM_W-1:0];
                got.any_busy    = o_m_tdata[ITEM_W];
                got.higher_busy = o_m_tdata[ITEM_W+1];
                if (awaited_replies.size() == 0) begin
                    err_count++;
                    $display("%0t: reply with none awaited, status %0d item %h", $time,
                             got.status, got.data);
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch("status", ITEM_W'(want.status), ITEM_W'(got.status));
                    if (got.data !== want.data)
                        flag_mismatch("item_out", want.data, got.data);
                    if (got.any_busy !== want.any_busy)
                        flag_mismatch("any_pending", ITEM_W'(want.any_busy),
                                      ITEM_W'(got.any_busy));
                    if (got.higher_busy !== want.higher_busy)
                        flag_mismatch("higher_pending", ITEM_W'(want.higher_busy),
                                      ITEM_W'(got.higher_busy));
                end
                if (o_m_tdata[M_TDATA_W-1:ITEM_W+2] !== '0)
                    flag_mismatch("tdata padding", '0,
                                  ITEM_W'(o_m_tdata[M_TDATA_W-1:ITEM_W+2]));
            end
            if (i_s_tvalid && o_s_tready) begin
                acc = 1;
                taken.cmd  = i_s_tuser;
                taken.qid  = i_s_tdata[ITEM_LSB-1:QID_LSB];
                taken.data = i_s_tdata[LEN_LSB-1:ITEM_LSB];
                taken.len  = i_s_tdata[SIZE_LSB-1:LEN_LSB];
                taken.size = i_s_tdata[SIZE_LSB+SIZE_W-1:SIZE_LSB];
                awaited_replies.push_back(apply_queue_op(taken));
            end
        end
        s_taken     <= i_rst_n && i_s_tvalid && o_s_tready;
        ops_taken   <= ops_taken + acc;
        replies_due <= replies_due + acc - ret;
    end

    // Queues one request and keeps the generator's fill levels in step.
    task automatic add_op(input logic [CMD_W-1:0] cmd, input int q,
                          input logic [ITEM_W-1:0] data, input int len,
                          input int size);
        t_req r;
        logic higher;
        higher = 1'b0;
        for (int h = q + 1; h < N_QUEUES; h++)
            if (fill_level[h] != 0)
                higher = 1'b1;
        if (cmd == CMD_PUSH && fill_level[q] < MAX_FILL)
            fill_level[q]++;
        else if (cmd == CMD_POP && !higher && fill_level[q] > 0)
            fill_level[q]--;
        r.cmd  = cmd;
        r.qid  = q[QID_W-1:0];
        r.data = data;
        r.len  = len[LEN_W-1:0];
        r.size = size[SIZE_W-1:0];
        op_backlog.push_back(r);
        ops_queued++;
    endtask

    function automatic logic [ITEM_W-1:0] rand_item();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random traffic in bursts: fills, priority-ordered drains, mixes, checks and noise.
    task automatic gen_random_ops(input int n);
        int made, k, q, top;
        logic [CMD_W-1:0] c;
        made = 0;
        while (made < n) begin
            k = $urandom_range(99);
            if (k < 35) begin
                // Fill one queue, often up to the point where it refuses.
                q = $urandom_range(N_QUEUES - 1);
                k = $urandom_range(1, 18);
                repeat (k) add_op(CMD_PUSH, q, rand_item(), $urandom, $urandom);
            end else if (k < 65) begin
                // Drain from the highest busy queue so that pops succeed.
                k = $urandom_range(1, 12);
                repeat (k) begin
                    top = -1;
                    for (int h = 0; h < N_QUEUES; h++)
                        if (fill_level[h] != 0)
                            top = h;
                    q = (top < 0) ? $urandom_range(N_QUEUES - 1) : top;
                    add_op(CMD_POP, q, rand_item(), $urandom, $urandom);
                end
            end else if (k < 82) begin
                // Mixed pushes and pops on random queues.
                k = $urandom_range(1, 10);
                repeat (k) begin
                    c = ($urandom_range(1) == 0) ? CMD_PUSH : CMD_POP;
                    add_op(c, $urandom_range(N_QUEUES - 1), rand_item(), $urandom, $urandom);
                end
            end else if (k < 92) begin
                // Settings checks, at least half of them matching.
                k = $urandom_range(1, 3);
                repeat (k) begin
                    case ($urandom_range(3))
                        0, 1: add_op(CMD_CHECK, $urandom_range(7), rand_item(),
                                     N_SLOTS, ELEM_BYTES);
                        2:    add_op(CMD_CHECK, $urandom_range(7), rand_item(),
                                     N_SLOTS + $urandom_range(1), $urandom_range(7, 9));
                        default: add_op(CMD_CHECK, $urandom_range(7), rand_item(),
                                        $urandom, $urandom);
                    endcase
                end
            end else begin
                // Unknown command or a pop on a random queue.
                k = 1;
                if ($urandom_range(1) == 0)
                    add_op(CMD_UNKNOWN, $urandom_range(N_QUEUES - 1), rand_item(),
                           $urandom, $urandom);
                else
                    add_op(CMD_POP, $urandom_range(N_QUEUES - 1), rand_item(),
                           $urandom, $urandom);
            end
            made += k;
        end
    endtask

    // Holds the sender until every request is taken and every reply has come back.
    task automatic wait_drained();
        while (ops_taken != ops_queued || replies_due != 0)
            @(posedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin : stimulus
        for (int q = 0; q < N_QUEUES; q++) begin
            rd_idx[q] = '0;
            wr_idx[q] = '0;
            fill_level[q] = 0;
            for (int s = 0; s < N_SLOTS; s++)
                slot_mem[q][s] = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 32;
        sink_idle_pct = 46;

        // Directed: extremes, priority gating, empty pops, checks and unknown commands.
        add_op(CMD_PUSH, 0, '1, 0, 0);
        add_op(CMD_PUSH, 7, '0, 255, 65535);
        add_op(CMD_POP, 0, '0, 0, 0);
        add_op(CMD_POP, 7, '1, 255, 65535);
        add_op(CMD_POP, 7, '0, 0, 0);
        add_op(CMD_POP, 0, '0, 0, 0);
        add_op(CMD_POP, 0, '0, 0, 0);
        add_op(CMD_PUSH, 5, 64'h0123_4567_89AB_CDEF, 0, 0);
        add_op(CMD_PUSH, 4, 64'hA5A5_5A5A_F00F_0FF0, 0, 0);
        add_op(CMD_POP, 4, '0, 0, 0);
        add_op(CMD_POP, 5, '0, 0, 0);
        add_op(CMD_POP, 4, '0, 0, 0);
        add_op(CMD_CHECK, 0, '0, N_SLOTS, ELEM_BYTES);
        add_op(CMD_CHECK, 7, '0, N_SLOTS, ELEM_BYTES + 1);
        add_op(CMD_CHECK, 3, '0, N_SLOTS - 1, ELEM_BYTES);
        add_op(CMD_CHECK, 2, '1, 255, 65535);
        add_op(CMD_CHECK, 1, '0, 0, 0);
        add_op(CMD_UNKNOWN, 3, '0, 0, 0);
        add_op(CMD_UNKNOWN, 7, '1, 255, 65535);
        add_op(CMD_POP, 6, '0, 0, 0);
        wait_drained();

        // Three pacing phases of random traffic; the sender pauses between them.
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 32 : (ph == 1) ? 46 : 0;
            sink_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 32 : 0;
            gen_random_ops(245);
            wait_drained();
        end

        // Wait on for any stray reply.
        repeat (12) @(posedge i_clk);

        $display("Run covered %0d transfers under three pacing phases.", ops_taken);
        $display("Pushes %0d stored / %0d full, pops %0d returned / %0d empty,",
                 n_push_ok, n_full, n_pop_ok, n_pop_empty);
        $display("%0d checks ok, %0d bad.", n_check_ok, n_bad);
        if (err_count == 0 && awaited_replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d errors, %0d replies never seen", err_count, awaited_replies.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== priority_gated_multi_queue_top.f =====
+incdir+design
design/pgmq_pkg.sv
design/pgmq_ctrl.sv
design/pgmq_dp.sv
design/priority_gated_multi_queue_top.sv
bench/priority_gated_multi_queue_top_tb.sv
